// ===== rtl/b64e_pkg.sv =====
// Shared types, constants and the Base64 symbol function for the stream encoder.
// Used by every module under rtl/; no dependencies of its own.
`default_nettype none

package b64e_pkg;

    localparam logic [7:0] PAD_STD     = 8'h3D;  // '='
    localparam logic [7:0] PAD_URL     = 8'h2E;  // '.'
    localparam logic [7:0] CHAR_UPPER  = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_LOWER  = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_DIGIT  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;  // '/'
    localparam logic [5:0] SYM_LOWER_START = 6'd26;
    localparam logic [5:0] SYM_DIGIT_START = 6'd52;
    localparam logic [5:0] SYM_PLUS        = 6'd62;

    // Position within the current three-byte group
    typedef enum logic [1:0] {
        PH0 = 2'd0,
        PH1 = 2'd1,
        PH2 = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } out_item_t;

    // One classified byte: up to four characters to emit
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;  // index of the final character in this entry
        logic            last;      // entry ends the encoded message
    } group_entry_t;

    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] v8;
        logic [7:0] res;
        v8 = {2'b00, v};
        priority if (v < SYM_LOWER_START)
            res = CHAR_UPPER + v8;
        else if (v < SYM_DIGIT_START)
            res = CHAR_LOWER + v8 - {2'b00, SYM_LOWER_START};
        else if (v < SYM_PLUS)
            res = CHAR_DIGIT + v8 - {2'b00, SYM_DIGIT_START};
        else if (v == SYM_PLUS)
            res = CHAR_PLUS;
        else
            res = CHAR_SLASH;
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/base64_stream_encoder_core.sv =====
// Top level of the Base64 stream encoder: pad register, front end, entry
// queue and character back end. Depends on b64e_pkg and the b64e_* modules.
`default_nettype none

// Encodes a byte stream to Base64 ASCII (A-Z a-z 0-9 + /), one byte per input
// transaction with a flag on the final byte, one character per output
// transaction. A byte is accepted in the cycle it is offered while the entry
// queue has room, and its characters leave through a registered output stage
// at one per cycle while out_stall is low, so a sustained stream yields four
// characters per three bytes, and a final byte yields up to four characters
// (two characters plus pads). The output character rate of the back end sets
// the throughput; QUEUE_DEPTH entries absorb bursts on the input side. The pad
// character is '=' or, with the pad-select bit set, '.'; write that bit only
// while idle.
module base64_stream_encoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire                        cfg_data,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire b64e_pkg::in_item_t    in_data,
    output logic                       out_valid,
    input  wire                        out_stall,
    output b64e_pkg::out_item_t        out_data
);

    logic                   dot_pad_reg;
    logic                   q_full;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_valid;
    b64e_pkg::group_entry_t wr_entry;
    b64e_pkg::group_entry_t rd_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dot_pad_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            dot_pad_reg <= cfg_data;
    end

    b64e_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .dot_pad  (dot_pad_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (wr_entry)
    );

    b64e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_entry (rd_entry)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (rd_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/b64e_front.sv =====
// Front end: accepts raw bytes, tracks group phase and leftover bits, and
// builds one character entry per byte. Depends on b64e_pkg.
`default_nettype none

module b64e_front (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      dot_pad,
    input  wire                      in_valid,
    output logic                     in_stall,
    input  wire b64e_pkg::in_item_t  in_data,
    input  wire                      q_full,
    output logic                     q_push,
    output b64e_pkg::group_entry_t   q_entry
);

    b64e_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       left_reg, left_next;
    logic             accept;
    logic [7:0]       b;
    logic [7:0]       pad;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;
    assign b        = in_data.in_byte;
    assign pad      = dot_pad ? b64e_pkg::PAD_URL : b64e_pkg::PAD_STD;

    // Next phase and leftover bits
    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        if (accept)
        begin
            unique case (phase_reg)
                b64e_pkg::PH1:
                begin
                    if (in_data.in_last)
                    begin
                        phase_next = b64e_pkg::PH0;
                        left_next  = 4'd0;
                    end
                    else
                    begin
                        phase_next = b64e_pkg::PH2;
                        left_next  = b[3:0];
                    end
                end
                b64e_pkg::PH2:
                begin
                    phase_next = b64e_pkg::PH0;
                    left_next  = 4'd0;
                end
                default:
                begin
                    if (in_data.in_last)
                    begin
                        phase_next = b64e_pkg::PH0;
                        left_next  = 4'd0;
                    end
                    else
                    begin
                        phase_next = b64e_pkg::PH1;
                        left_next  = {2'b00, b[1:0]};
                    end
                end
            endcase
        end
    end

    // Entry contents for the byte on the input
    always_comb
    begin
        q_entry          = '0;
        q_entry.chars[1] = pad;
        q_entry.chars[2] = pad;
        q_entry.chars[3] = pad;
        unique case (phase_reg)
            b64e_pkg::PH1:
            begin
                q_entry.chars[0] = b64e_pkg::b64_sym({left_reg[1:0], b[7:4]});
                if (in_data.in_last)
                begin
                    q_entry.chars[1] = b64e_pkg::b64_sym({b[3:0], 2'b00});
                    q_entry.last_idx = 2'd2;
                    q_entry.last     = 1'b1;
                end
            end
            b64e_pkg::PH2:
            begin
                q_entry.chars[0] = b64e_pkg::b64_sym({left_reg, b[7:6]});
                q_entry.chars[1] = b64e_pkg::b64_sym(b[5:0]);
                q_entry.last_idx = 2'd1;
                q_entry.last     = in_data.in_last;
            end
            default:
            begin
                q_entry.chars[0] = b64e_pkg::b64_sym(b[7:2]);
                if (in_data.in_last)
                begin
                    q_entry.chars[1] = b64e_pkg::b64_sym({b[1:0], 4'b0000});
                    q_entry.last_idx = 2'd3;
                    q_entry.last     = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64e_pkg::PH0;
            left_reg  <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/b64e_fifo.sv =====
// Short entry queue between the byte front end and the character back end.
// Depends on b64e_pkg for the entry type.
`default_nettype none

module b64e_fifo #(
    parameter int DEPTH = 4
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push,
    input  wire b64e_pkg::group_entry_t wr_entry,
    output logic                    full,
    input  wire                     pop,
    output logic                    rd_valid,
    output b64e_pkg::group_entry_t  rd_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64e_pkg::group_entry_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

    a_ptrs_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

// ===== rtl/b64e_back.sv =====
// Back end: takes entries from the queue and emits one character per cycle
// through an output register while out_stall is low. Depends on b64e_pkg.
`default_nettype none

module b64e_back (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         q_valid,
    input  wire b64e_pkg::group_entry_t q_entry,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire                         out_stall,
    output b64e_pkg::out_item_t         out_data
);

    b64e_pkg::group_entry_t cur_reg;
    logic                   cur_valid_reg;
    logic [1:0]             idx_reg;
    logic                   out_valid_reg;
    b64e_pkg::out_item_t    out_data_reg;

    logic load;
    logic at_end;
    logic cur_take;

    assign at_end   = (idx_reg == cur_reg.last_idx);
    assign load     = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign cur_take = q_valid && (!cur_valid_reg || (load && at_end));
    assign q_pop    = cur_take;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (cur_take)
            cur_reg <= q_entry;
        if (load)
        begin
            out_data_reg.out_char <= cur_reg.chars[idx_reg];
            out_data_reg.out_last <= cur_reg.last && at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // hold output until taken, then refill from the current entry
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (cur_take)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (load)
            begin
                if (at_end)
                begin
                    cur_valid_reg <= 1'b0;
                    idx_reg       <= 2'd0;
                end
                else
                    idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire
